// ===== design/cfp_pkg.sv =====
// Shared constants and types for the control frame packer.
// Used by cfp_framer, cfp_cell, the top level and its checker.
`default_nettype none

package cfp_pkg;

  localparam int unsigned FRAME_LEN   = 13;
  localparam int unsigned PAYLOAD_LEN = 8;
  localparam int unsigned IDX_W       = 2;

  localparam logic [7:0] SYNC_BYTE = 8'h55;
  localparam logic [7:0] ESC_BYTE  = 8'h56;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_FRAME_MODE = 2'd0;
  localparam logic [IDX_W-1:0] REG_LATITUDE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_LONGITUDE  = 2'd2;
  localparam logic [IDX_W-1:0] REG_SEND_EN    = 2'd3;

  // Contents of one cell of the output chain
  typedef struct packed {
    logic       vld;
    logic       last;
    logic [7:0] data;
  } slot_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

endpackage

`default_nettype wire

// ===== design/cfp_framer.sv =====
// Builds the thirteen frame bytes of one tick: sync, header, escaped payload,
// escape map and checksum. Depends on cfp_pkg.
`default_nettype none

module cfp_framer (
  input  wire logic               frame_mode_i,
  input  wire logic [31:0]        latitude_i,
  input  wire logic [31:0]        longitude_i,
  input  wire logic [15:0]        right_stick_x_i,
  input  wire logic [15:0]        right_stick_y_i,
  input  wire logic [15:0]        left_stick_x_i,
  input  wire logic [15:0]        left_stick_y_i,
  input  wire logic               button_a_i,
  input  wire logic               button_b_i,
  input  wire logic               button_x_i,
  input  wire logic               button_y_i,
  output cfp_pkg::frame_t         frame_o
);

  logic [cfp_pkg::PAYLOAD_LEN-1:0][7:0] raw;
  logic [cfp_pkg::PAYLOAD_LEN-1:0][7:0] esc;
  logic [7:0]                           header;
  logic [7:0]                           esc_map;
  logic [7:0]                           sum;

  assign header = {1'b0, frame_mode_i, 2'b00, button_x_i, button_b_i, button_a_i, button_y_i};

  // Payload byte i goes out i-th, high byte of each word first
  always_comb begin
    if (frame_mode_i) begin
      raw[0] = latitude_i[31:24];
      raw[1] = latitude_i[23:16];
      raw[2] = latitude_i[15:8];
      raw[3] = latitude_i[7:0];
      raw[4] = longitude_i[31:24];
      raw[5] = longitude_i[23:16];
      raw[6] = longitude_i[15:8];
      raw[7] = longitude_i[7:0];
    end else begin
      raw[0] = right_stick_x_i[15:8];
      raw[1] = right_stick_x_i[7:0];
      raw[2] = right_stick_y_i[15:8];
      raw[3] = right_stick_y_i[7:0];
      raw[4] = left_stick_x_i[15:8];
      raw[5] = left_stick_x_i[7:0];
      raw[6] = left_stick_y_i[15:8];
      raw[7] = left_stick_y_i[7:0];
    end
  end

  // Replace sync look-alikes and mark them, first payload byte in bit 7
  always_comb begin
    esc_map = '0;
    for (int i = 0; i < cfp_pkg::PAYLOAD_LEN; i++) begin
      if (raw[i] == cfp_pkg::SYNC_BYTE) begin
        esc[i] = cfp_pkg::ESC_BYTE;
        esc_map[cfp_pkg::PAYLOAD_LEN-1-i] = 1'b1;
      end else begin
        esc[i] = raw[i];
      end
    end
  end

  always_comb begin
    sum = header ^ esc_map;
    for (int i = 0; i < cfp_pkg::PAYLOAD_LEN; i++) begin
      sum = sum ^ esc[i];
    end
  end

  always_comb begin
    frame_o[0] = cfp_pkg::SYNC_BYTE;
    frame_o[1] = cfp_pkg::SYNC_BYTE;
    frame_o[2] = header;
    for (int i = 0; i < cfp_pkg::PAYLOAD_LEN; i++) begin
      frame_o[3+i] = esc[i];
    end
    frame_o[cfp_pkg::FRAME_LEN-2] = esc_map;
    frame_o[cfp_pkg::FRAME_LEN-1] = sum;
  end

endmodule

`default_nettype wire

// ===== design/cfp_cell.sv =====
// One cell of the output chain: holds one frame byte, loads in parallel,
// and takes its neighbor's byte on an advance without a load. Depends on cfp_pkg.
`default_nettype none

module cfp_cell (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           load_i,
  input  wire logic           shift_i,
  input  wire cfp_pkg::slot_t load_slot_i,
  input  wire cfp_pkg::slot_t nbr_slot_i,
  output cfp_pkg::slot_t      slot_o
);

  logic       vld_q;
  logic       last_q;
  logic [7:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load_i) begin
      vld_q <= load_slot_i.vld;
    end else if (shift_i) begin
      vld_q <= nbr_slot_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      last_q <= load_slot_i.last;
      data_q <= load_slot_i.data;
    end else if (shift_i) begin
      last_q <= nbr_slot_i.last;
      data_q <= nbr_slot_i.data;
    end
  end

  assign slot_o = '{vld: vld_q, last: last_q, data: data_q};

endmodule

`default_nettype wire

// ===== design/control_frame_packer_top.sv =====
// Control frame packer: one tick in, one 13-byte framed message out while send_en is set.
// The first byte is registered and valid in the cycle after the tick transfer.
// Output: one byte per cycle while m_axis_tready is high. A new tick is taken only
// when the 13-cell output chain, which empties one byte per output transfer, is empty or its final byte leaves.
// Reset: rst_ni is asynchronous, active low; config registers read 0, chain empty.
// Depends on cfp_pkg, cfp_framer and cfp_cell.
`default_nettype none

module control_frame_packer_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // Configuration write channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [cfp_pkg::IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]               cfg_data_i,
  // Tick input stream
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata, low bit up: right_stick_x[15:0], right_stick_y[31:16],
  // left_stick_x[47:32], left_stick_y[63:48], button_a[64], button_b[65],
  // button_x[66], button_y[67], zero fill [71:68]
  input  wire logic [71:0]               s_axis_tdata,
  // Frame byte output stream
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // tdata: frame_byte[7:0]
  output logic [7:0]                     m_axis_tdata,
  // tlast: last_byte, set on the checksum byte
  output logic                           m_axis_tlast
);

  localparam int unsigned N = cfp_pkg::FRAME_LEN;

  // Configuration registers
  logic        frame_mode_q;
  logic [31:0] latitude_q;
  logic [31:0] longitude_q;
  logic        send_en_q;

  // Writes land at any time; the block uses them only when it takes a tick.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q <= 1'b0;
      latitude_q   <= '0;
      longitude_q  <= '0;
      send_en_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        cfp_pkg::REG_FRAME_MODE: frame_mode_q <= cfg_data_i[0];
        cfp_pkg::REG_LATITUDE:   latitude_q   <= cfg_data_i;
        cfp_pkg::REG_LONGITUDE:  longitude_q  <= cfg_data_i;
        cfp_pkg::REG_SEND_EN:    send_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Frame assembly from the tick on the input bus
  cfp_pkg::frame_t frame;

  cfp_framer u_framer (
    .frame_mode_i    (frame_mode_q),
    .latitude_i      (latitude_q),
    .longitude_i     (longitude_q),
    .right_stick_x_i (s_axis_tdata[15:0]),
    .right_stick_y_i (s_axis_tdata[31:16]),
    .left_stick_x_i  (s_axis_tdata[47:32]),
    .left_stick_y_i  (s_axis_tdata[63:48]),
    .button_a_i      (s_axis_tdata[64]),
    .button_b_i      (s_axis_tdata[65]),
    .button_x_i      (s_axis_tdata[66]),
    .button_y_i      (s_axis_tdata[67]),
    .frame_o         (frame)
  );

  // Output chain: cell 0 drives the output, cell i takes cell i+1 on advance.
  cfp_pkg::slot_t slot [N];
  cfp_pkg::slot_t nbr  [N];
  cfp_pkg::slot_t ld   [N];

  logic shift;
  logic tick_xfer;
  logic load;

  // Advance on every output transfer.
  assign shift = slot[0].vld && m_axis_tready;

  // Take a tick when the chain is empty, or when only the final byte sits
  // in cell 0 and leaves this cycle, so frames follow without a gap.
  assign s_axis_tready = !slot[1].vld && (!slot[0].vld || m_axis_tready);
  assign tick_xfer     = s_axis_tvalid && s_axis_tready;
  // Drop the tick when sending is off.
  assign load          = tick_xfer && send_en_q;

  for (genvar g = 0; g < N; g++) begin : g_chain
    assign ld[g] = '{vld: 1'b1, last: (g == N - 1), data: frame[g]};
    if (g == N - 1) begin : g_tail
      assign nbr[g] = '{vld: 1'b0, last: 1'b0, data: 8'h00};
    end else begin : g_body
      assign nbr[g] = slot[g+1];
    end

    cfp_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .load_i      (load),
      .shift_i     (shift),
      .load_slot_i (ld[g]),
      .nbr_slot_i  (nbr[g]),
      .slot_o      (slot[g])
    );
  end

  assign m_axis_tvalid = slot[0].vld;
  assign m_axis_tdata  = slot[0].data;
  assign m_axis_tlast  = slot[0].last;

endmodule

`default_nettype wire

// ===== design/cfp_checker.sv =====
// Port-level checks for control_frame_packer_top, bound to the top level.
// Depends on cfp_pkg.
`default_nettype none

module cfp_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata,
  input wire logic       m_axis_tlast
);

  // A stalled output byte holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output byte changed while stalled");

  // No tick is taken while a frame still has bytes beyond the current one.
  a_no_tick_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("tick taken in the middle of a frame");

  // A frame does not pause between its bytes.
  a_frame_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a frame");

  // A byte shown right after a frame ends opens the next frame with sync.
  a_sync_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=>
      !m_axis_tvalid || (m_axis_tdata == cfp_pkg::SYNC_BYTE && !m_axis_tlast))
    else $error("frame does not open with sync");

endmodule

bind control_frame_packer_top cfp_checker u_cfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== verif/control_frame_packer_top_test.sv =====
// Self-checking testbench for control_frame_packer_top: drives ticks and register
// writes, predicts every 13-byte frame and checks the byte stream against it.
// Depends on cfp_pkg and the control_frame_packer_top RTL.
`timescale 1ns / 1ps

module control_frame_packer_top_test;
  import cfp_pkg::*;

  // Half clock period, and the longest run of cycles without any transfer before
  // the run is declared hung. The limit leaves a wide margin over the slowest
  // correct run, even at a 70% stall rate.
  localparam int unsigned HALF_PERIOD = 4;
  localparam int unsigned STALL_LIMIT = 2000;
  // Cycles to let pass after the last expected byte before touching registers
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 20;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned TICKS_PER_PHASE = 43;

  // One predicted byte of the output stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  // Predicts frames from its own copy of the registers and checks the bytes
  class frame_scoreboard;
    logic        mode;
    logic [31:0] lat_word;
    logic [31:0] lon_word;
    logic        enable;
    frame_byte_t pending_bytes[$];
    int unsigned mismatches;

    function new();
      mode = 1'b0;
      lat_word = '0;
      lon_word = '0;
      enable = 1'b0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        REG_FRAME_MODE: mode = val[0];
        REG_LATITUDE:   lat_word = val;
        REG_LONGITUDE:  lon_word = val;
        REG_SEND_EN:    enable = val[0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic [71:0] d);
      logic [7:0]  fr[FRAME_LEN];
      logic [63:0] payload;
      logic [7:0]  map;
      logic [7:0]  sum;
      frame_byte_t e;
      if (!enable) return;
      fr[0] = SYNC_BYTE;
      fr[1] = SYNC_BYTE;
      // header: mode in bit 6, then X, B, A, Y from bit 3 down
      fr[2] = {1'b0, mode, 2'b00, d[66], d[65], d[64], d[67]};
      if (mode) payload = {lat_word, lon_word};
      else      payload = {d[15:0], d[31:16], d[47:32], d[63:48]};
      map = '0;
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
        fr[3+i] = payload[63-8*i -: 8];
        if (fr[3+i] == SYNC_BYTE) begin
          fr[3+i] = ESC_BYTE;
          map[7-i] = 1'b1;
        end
      end
      fr[11] = map;
      sum = '0;
      for (int i = 2; i < 12; i++) sum = sum ^ fr[i];
      fr[12] = sum;
      for (int i = 0; i < FRAME_LEN; i++) begin
        e.data = fr[i];
        e.last = (i == FRAME_LEN - 1);
        pending_bytes.push_back(e);
      end
    endfunction

    function void flag(string what, logic [7:0] want, logic [7:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] mismatch on %s: expected 0x%02h, got 0x%02h", $time, what, want, got);
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      frame_byte_t e;
      if (pending_bytes.size() == 0) begin
        flag("unexpected byte", 8'h00, data);
        return;
      end
      e = pending_bytes.pop_front();
      if (e.data !== data) flag("frame byte", e.data, data);
      if (e.last !== last) flag("tlast", {7'd0, e.last}, {7'd0, last});
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [31:0]       cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [71:0]       s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic              m_axis_tlast;

  frame_scoreboard   sb;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       stall_cycles = 0;

  control_frame_packer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // Receiver: check each byte transfer, then stall at random for the next edge.
  // Values read here at the edge are the ones from before it, so a transfer is
  // seen exactly when the block sees it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) sb.check_byte(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Watchdog: count cycles in which no transfer happens on any channel
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("control_frame_packer_top regression: fail");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Pack one tick into tdata; buttons are {y, x, b, a}
  function automatic logic [71:0] pack_tick(logic [15:0] rx, logic [15:0] ry,
                                            logic [15:0] lx, logic [15:0] ly,
                                            logic [3:0] btn);
    return {4'b0000, btn[3], btn[2], btn[1], btn[0], ly, lx, ry, rx};
  endfunction

  // Stick value biased toward extremes and bytes that need escaping
  function automatic logic [15:0] rand_stick();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return {SYNC_BYTE, 8'($urandom)};
      5: return {8'($urandom), SYNC_BYTE};
      6: return {SYNC_BYTE, SYNC_BYTE};
      default: return 16'($urandom);
    endcase
  endfunction

  // Position word: extremes, or bytes that are often the sync value
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(0, 5))
      0: w = 32'h8000_0000;
      1: w = 32'h7FFF_FFFF;
      2: w = 32'hFFFF_FFFF;
      default: begin
        w = $urandom;
        for (int i = 0; i < 4; i++)
          if ($urandom_range(0, 3) == 0) w[8*i +: 8] = SYNC_BYTE;
      end
    endcase
    return w;
  endfunction

  // Write one register; lower valid afterwards and advance to the next clock edge
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one tick after a random gap; valid stays high on return so a
  // back-to-back tick is never lowered and raised in the same step
  task automatic put_tick(logic [71:0] d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_tick(d);
  endtask

  // Hold the sender until every predicted byte has come out
  task automatic wait_frames_out();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Drain, then let the block go fully idle before a register write
  task automatic settle();
    wait_frames_out();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: sender 26% idle, receiver 70% idle
    send_idle_pct = 26;
    recv_idle_pct = 70;

    // Sending is off after reset: these ticks must produce nothing
    put_tick(pack_tick(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 4'b1111));
    put_tick(pack_tick(16'h5555, 16'h0000, 16'hFFFF, 16'h8000, 4'b0101));
    settle();

    // Stick mode; excess bits above bit 0 of the one-bit registers are dropped
    write_reg(REG_FRAME_MODE, 32'hFFFF_FFFE);
    write_reg(REG_LATITUDE, 32'h0000_0000);
    write_reg(REG_LONGITUDE, 32'h0000_0000);
    write_reg(REG_SEND_EN, 32'hFFFF_FFFF);

    put_tick(pack_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b0000));
    put_tick(pack_tick(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'b1111));
    put_tick(pack_tick(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 4'b0000));
    // Each button alone: a, b, x, y
    put_tick(pack_tick(16'h0001, 16'h0000, 16'h0000, 16'h0000, 4'b0001));
    put_tick(pack_tick(16'h0000, 16'h0100, 16'h0000, 16'h0000, 4'b0010));
    put_tick(pack_tick(16'h0000, 16'h0000, 16'h0001, 16'h0000, 4'b0100));
    put_tick(pack_tick(16'h0000, 16'h0000, 16'h0000, 16'h0100, 4'b1000));
    // Every payload byte escaped: map is all ones
    put_tick(pack_tick(16'h5555, 16'h5555, 16'h5555, 16'h5555, 4'b0000));
    // Only the low bytes escaped: the map itself equals the sync value
    put_tick(pack_tick(16'h1255, 16'h3455, 16'h5655, 16'h7855, 4'b0000));
    // Checksum lands on the sync value and must go out unescaped
    put_tick(pack_tick(16'h5400, 16'h0100, 16'h0000, 16'h0000, 4'b0000));
    put_tick(pack_tick(16'h55AA, 16'h5501, 16'h55FF, 16'h5580, 4'b1010));
    settle();

    // Position mode with escaped bytes and sign extremes in the words
    write_reg(REG_FRAME_MODE, 32'h0000_0003);
    write_reg(REG_LATITUDE, 32'h5555_5555);
    write_reg(REG_LONGITUDE, 32'h8000_0000);
    put_tick(pack_tick(16'h1111, 16'h2222, 16'h3333, 16'h4444, 4'b1001));
    put_tick(pack_tick(16'h5555, 16'h5555, 16'h5555, 16'h5555, 4'b0110));
    settle();
    write_reg(REG_LATITUDE, 32'h7FFF_FFFF);
    write_reg(REG_LONGITUDE, 32'h0055_0055);
    put_tick(pack_tick(16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'b1111));
    settle();
    write_reg(REG_LATITUDE, 32'hFFFF_FFFF);
    write_reg(REG_LONGITUDE, 32'h0000_0000);
    put_tick(pack_tick(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 4'b0000));
    settle();

    // Random part: two phases per idle profile, alternating the payload mode
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p / 2)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      settle();
      write_reg(REG_FRAME_MODE, {31'($urandom), p[0]});
      write_reg(REG_LATITUDE, rand_word());
      write_reg(REG_LONGITUDE, rand_word());
      write_reg(REG_SEND_EN, {31'($urandom), 1'b1});
      for (int n = 0; n < TICKS_PER_PHASE; n++) begin
        // Hold the sender once mid-stream until the block has emptied
        if (p == 2 && n == TICKS_PER_PHASE / 2) wait_frames_out();
        put_tick(pack_tick(rand_stick(), rand_stick(), rand_stick(), rand_stick(),
                           4'($urandom)));
      end
      // A short stretch with sending off: ticks are taken and dropped
      if (p == 3) begin
        settle();
        write_reg(REG_SEND_EN, {31'($urandom), 1'b0});
        for (int n = 0; n < 8; n++)
          put_tick(pack_tick(rand_stick(), rand_stick(), rand_stick(), rand_stick(),
                             4'($urandom)));
      end
    end

    // Drain, let the tail run out, then judge
    wait_frames_out();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("control_frame_packer_top regression: pass");
    end else begin
      $display("control_frame_packer_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/cfp_pkg.sv
design/cfp_framer.sv
design/cfp_cell.sv
design/control_frame_packer_top.sv
design/cfp_checker.sv
verif/control_frame_packer_top_test.sv
